[hdl/jmq_pkg.sv]
// Shared types and constants for the joypad merge / minimum-press qualifier.
// No dependencies; every other file imports this package.
package jmq_pkg;

  localparam int CONTROLS_PER_GROUP_DEF = 4;
  localparam int TIME_WIDTH_DEF         = 32;

  localparam int OPCODE_W  = 2;
  localparam int ZONE_W    = 4;
  localparam int NOW_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int GRP_OUT_W = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TOUCH  = 2'd0,
    OP_REMOTE = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESS      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_TIMEOUT = 1'd1;

  localparam logic [CFG_W-1:0] MIN_PRESS_RST      = 16'd50;
  localparam logic [CFG_W-1:0] REMOTE_TIMEOUT_RST = 16'd0;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic                touch_present;
    logic [ZONE_W-1:0]   touch_zone;
    logic [ZONE_W-1:0]   control_index;
    logic                pressed;
    logic [NOW_W-1:0]    now_ms;
  } in_item_t;

  typedef struct packed {
    logic [GRP_OUT_W-1:0] merged_buttons;
    logic [GRP_OUT_W-1:0] merged_directions;
    logic [GRP_OUT_W-1:0] remote_buttons;
    logic [GRP_OUT_W-1:0] remote_directions;
    logic                 joypad_irq;
  } out_item_t;

  typedef struct packed {
    logic in_valid;
    logic fire;
  } stage_ctl_t;

endpackage

[hdl/jmq_in_if.sv]
// Input channel interface: valid/ready plus the event fields.
// Depends on jmq_pkg.
interface jmq_in_if import jmq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic                touch_present;
  logic [ZONE_W-1:0]   touch_zone;
  logic [ZONE_W-1:0]   control_index;
  logic                pressed;
  logic [NOW_W-1:0]    now_ms;

  modport source (output valid, opcode, touch_present, touch_zone, control_index,
                  pressed, now_ms, input ready);
  modport sink   (input valid, opcode, touch_present, touch_zone, control_index,
                  pressed, now_ms, output ready);
endinterface

[hdl/jmq_out_if.sv]
// Result channel interface: valid/ready plus the joypad masks and interrupt.
// Depends on jmq_pkg.
interface jmq_out_if import jmq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [GRP_OUT_W-1:0] merged_buttons;
  logic [GRP_OUT_W-1:0] merged_directions;
  logic [GRP_OUT_W-1:0] remote_buttons;
  logic [GRP_OUT_W-1:0] remote_directions;
  logic                 joypad_irq;

  modport source (output valid, merged_buttons, merged_directions, remote_buttons,
                  remote_directions, joypad_irq, input ready);
  modport sink   (input valid, merged_buttons, merged_directions, remote_buttons,
                  remote_directions, joypad_irq, output ready);
endinterface

[hdl/joypad_merge_min_press_qualifier_core.sv]
// Top level of the joypad merge with minimum-press qualifier.
// Depends on jmq_pkg, jmq_in_if, jmq_out_if, jmq_in_reg, jmq_update, jmq_out_reg.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+----------------------------------------
//   in_chan  | in  | valid/ready       | opcode, touch, remote control, now_ms
//   out_chan | out | valid/ready       | merged/remote masks, joypad_irq
//   cfg_*    | in  | cfg_we, no ready  | cfg_index, cfg_wdata (16 bit)
//
// One item per cycle while the result side does not stall; an item passes the input
// register, then the result register, before its result can transfer.
// The state update is one pass of compares, one add and one subtract; no stall of its own.
// rst_n is synchronous: clears all joypad state, min press 50 ms, timeout off.
// A stalled result holds the update stage; the input register then fills and drops ready.
module joypad_merge_min_press_qualifier_core import jmq_pkg::*; #(
  parameter int CONTROLS_PER_GROUP = CONTROLS_PER_GROUP_DEF,
  parameter int TIME_WIDTH         = TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  jmq_in_if.sink               in_chan,
  jmq_out_if.source            out_chan
);

  stage_ctl_t ctl;
  in_item_t   item;
  out_item_t  result;
  logic       out_free;

  assign ctl.fire = ctl.in_valid && out_free;

  jmq_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .fire    (ctl.fire),
    .valid_r (ctl.in_valid),
    .item_r  (item)
  );

  jmq_update #(
    .CONTROLS_PER_GROUP (CONTROLS_PER_GROUP),
    .TIME_WIDTH         (TIME_WIDTH)
  ) u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (ctl.fire),
    .item      (item),
    .result    (result)
  );

  jmq_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .result   (result),
    .free     (out_free),
    .out_chan (out_chan)
  );

endmodule

[hdl/jmq_in_reg.sv]
// Input register: captures one event per transfer on the input channel.
// Depends on jmq_pkg and jmq_in_if.
module jmq_in_reg import jmq_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  jmq_in_if.sink        in_chan,
  input  logic          fire,
  output logic          valid_r,
  output in_item_t      item_r
);

  logic     valid_nxt;
  logic     load;

  assign in_chan.ready = !valid_r || fire;
  assign load          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.opcode        <= in_chan.opcode;
      item_r.touch_present <= in_chan.touch_present;
      item_r.touch_zone    <= in_chan.touch_zone;
      item_r.control_index <= in_chan.control_index;
      item_r.pressed       <= in_chan.pressed;
      item_r.now_ms        <= in_chan.now_ms;
    end
  end

endmodule

[hdl/jmq_update.sv]
// Joypad state, config registers and the combinational next-state/result logic.
// Depends on jmq_pkg.
module jmq_update import jmq_pkg::*; #(
  parameter int CONTROLS_PER_GROUP = CONTROLS_PER_GROUP_DEF,
  parameter int TIME_WIDTH         = TIME_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 fire,
  input  in_item_t             item,
  output out_item_t            result
);

  localparam int NCTRL = 2 * CONTROLS_PER_GROUP;
  localparam int CMP_W = ZONE_W + 1;

  logic [CFG_W-1:0]      min_press_r;
  logic [CFG_W-1:0]      timeout_r;

  logic [NCTRL-1:0]      touch_r, touch_nxt;
  logic [NCTRL-1:0]      remote_r, remote_nxt;
  logic [NCTRL-1:0]      checked_r, checked_nxt;
  logic [TIME_WIDTH-1:0] press_r   [NCTRL];
  logic [TIME_WIDTH-1:0] press_nxt [NCTRL];
  logic [TIME_WIDTH-1:0] due_r     [NCTRL];
  logic [TIME_WIDTH-1:0] due_nxt   [NCTRL];
  logic [TIME_WIDTH-1:0] last_r, last_nxt;

  logic [TIME_WIDTH-1:0] now;
  logic [NCTRL-1:0]      zone_hit;
  logic [NCTRL-1:0]      ctrl_sel;
  logic [NCTRL-1:0]      due_nz;
  logic [TIME_WIDTH-1:0] press_sel;
  logic [TIME_WIDTH-1:0] earliest;
  logic [TIME_WIDTH-1:0] due_new;
  logic                  timeout_hit;
  logic [NCTRL-1:0]      merged;
  logic [NCTRL-1:0]      cur;
  logic                  irq;

  assign now = TIME_WIDTH'(item.now_ms);

  always_comb begin
    press_sel = '0;
    for (int i = 0; i < NCTRL; i++) begin
      zone_hit[i] = item.touch_present &&
                    (CMP_W'(item.touch_zone) == CMP_W'(i));
      ctrl_sel[i] = (CMP_W'(item.control_index) == CMP_W'(i));
      due_nz[i]   = (due_r[i] != '0);
      press_sel   = press_sel | (ctrl_sel[i] ? press_r[i] : '0);
    end
  end

  assign earliest = press_sel + TIME_WIDTH'(min_press_r);
  assign due_new  = (now < earliest) ? earliest : now;

  assign timeout_hit = (remote_r != '0) && (timeout_r != '0) && (last_r != '0) &&
                       (now >= last_r) && ((now - last_r) > TIME_WIDTH'(timeout_r));

  always_comb begin
    touch_nxt   = touch_r;
    remote_nxt  = remote_r;
    checked_nxt = checked_r;
    press_nxt   = press_r;
    due_nxt     = due_r;
    last_nxt    = last_r;
    irq         = 1'b0;
    cur         = '0;
    unique case (item.opcode)
      OP_TOUCH: begin
        touch_nxt = zone_hit;
        if (item.touch_present) begin
          cur         = zone_hit | remote_r;
          irq         = |(cur & ~checked_r);
          checked_nxt = cur;
        end
      end
      OP_REMOTE: begin
        for (int i = 0; i < NCTRL; i++) begin
          if (ctrl_sel[i]) begin
            if (item.pressed) begin
              if (!remote_r[i]) begin
                press_nxt[i] = now;
              end
              due_nxt[i]    = '0;
              remote_nxt[i] = 1'b1;
            end else begin
              due_nxt[i] = due_new;
            end
          end
        end
        last_nxt = now;
      end
      OP_TICK: begin
        if ((remote_r != '0) || (due_nz != '0)) begin
          if (timeout_hit) begin
            remote_nxt = '0;
            for (int i = 0; i < NCTRL; i++) begin
              press_nxt[i] = '0;
              due_nxt[i]   = '0;
            end
            last_nxt = '0;
          end else begin
            for (int i = 0; i < NCTRL; i++) begin
              if (due_nz[i] && (now >= due_r[i])) begin
                remote_nxt[i] = 1'b0;
                due_nxt[i]    = '0;
              end
            end
          end
          cur         = touch_r | remote_nxt;
          irq         = |(cur & ~checked_r);
          checked_nxt = cur;
        end
      end
      OP_CLEAR: begin
        remote_nxt = '0;
        for (int i = 0; i < NCTRL; i++) begin
          press_nxt[i] = '0;
          due_nxt[i]   = '0;
        end
        last_nxt = '0;
      end
      default: ;
    endcase
  end

  assign merged = touch_nxt | remote_nxt;

  // groups wider than the output field are truncated, narrower ones zero-padded
  for (genvar b = 0; b < GRP_OUT_W; b++) begin : g_out
    if (b < CONTROLS_PER_GROUP) begin : g_bit
      assign result.merged_buttons[b]    = merged[b];
      assign result.merged_directions[b] = merged[CONTROLS_PER_GROUP + b];
      assign result.remote_buttons[b]    = remote_nxt[b];
      assign result.remote_directions[b] = remote_nxt[CONTROLS_PER_GROUP + b];
    end else begin : g_pad
      assign result.merged_buttons[b]    = 1'b0;
      assign result.merged_directions[b] = 1'b0;
      assign result.remote_buttons[b]    = 1'b0;
      assign result.remote_directions[b] = 1'b0;
    end
  end
  assign result.joypad_irq = irq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_press_r <= MIN_PRESS_RST;
      timeout_r   <= REMOTE_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PRESS:      min_press_r <= cfg_wdata;
        CFG_REMOTE_TIMEOUT: timeout_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_r   <= '0;
      remote_r  <= '0;
      checked_r <= '0;
      last_r    <= '0;
      for (int i = 0; i < NCTRL; i++) begin
        press_r[i] <= '0;
        due_r[i]   <= '0;
      end
    end else if (fire) begin
      touch_r   <= touch_nxt;
      remote_r  <= remote_nxt;
      checked_r <= checked_nxt;
      last_r    <= last_nxt;
      press_r   <= press_nxt;
      due_r     <= due_nxt;
    end
  end

endmodule

[hdl/jmq_out_reg.sv]
// Result register: holds one result until the sink takes the transfer.
// Depends on jmq_pkg and jmq_out_if.
module jmq_out_reg import jmq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t ctl,
  input  out_item_t  result,
  output logic       free,
  jmq_out_if.source  out_chan
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign free = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.fire) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      item_r <= result;
    end
  end

  assign out_chan.valid             = valid_r;
  assign out_chan.merged_buttons    = item_r.merged_buttons;
  assign out_chan.merged_directions = item_r.merged_directions;
  assign out_chan.remote_buttons    = item_r.remote_buttons;
  assign out_chan.remote_directions = item_r.remote_directions;
  assign out_chan.joypad_irq        = item_r.joypad_irq;

endmodule

[hdl/jmq_checker.sv]
// Port-level checks for the joypad merge core, bound to the top level.
// Depends on jmq_pkg and joypad_merge_min_press_qualifier_core.
module jmq_checker import jmq_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [GRP_OUT_W-1:0] merged_buttons,
  input logic [GRP_OUT_W-1:0] merged_directions,
  input logic [GRP_OUT_W-1:0] remote_buttons,
  input logic [GRP_OUT_W-1:0] remote_directions,
  input logic                 joypad_irq
);

  // remote bits always show in the merged mask
  a_remote_in_merged: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((merged_buttons & remote_buttons) == remote_buttons) &&
                  ((merged_directions & remote_directions) == remote_directions))
    else $error("remote mask not contained in merged mask");

  // with the result register empty the pipe must take a transfer
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready with empty result register");

  // result valid after an input transfer, through the input register and then the result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("result missing two cycles after input transfer");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(merged_buttons) &&
      $stable(merged_directions) && $stable(remote_buttons) &&
      $stable(remote_directions) && $stable(joypad_irq))
    else $error("stalled result changed");

endmodule

bind joypad_merge_min_press_qualifier_core jmq_checker u_jmq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .merged_buttons    (out_chan.merged_buttons),
  .merged_directions (out_chan.merged_directions),
  .remote_buttons    (out_chan.remote_buttons),
  .remote_directions (out_chan.remote_directions),
  .joypad_irq        (out_chan.joypad_irq)
);

[tb/sv/tb_top.sv]
// Self-checking bench for joypad_merge_min_press_qualifier_core: directed table, then random
// phases under several register settings, each result checked against a table value or an in-bench predictor.
// Depends on jmq_pkg, jmq_in_if, jmq_out_if and the core RTL.
module tb_top;
  import jmq_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    in_item_t  ev;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  bit clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  jmq_in_if  in_chan ();
  jmq_out_if out_chan ();

  joypad_merge_min_press_qualifier_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [CFG_W-1:0] min_press, rem_timeout;
  logic [7:0]       touch_m, remote_m, checked_m;
  logic [31:0]      press_t [8];
  logic [31:0]      due_t [8];
  logic [31:0]      last_rem_t;
  logic [31:0]      t_now;

  out_item_t expected_joypad_q [$];
  int events_sent, results_checked, mismatches, stall_cycles, phases_run;
  bit tx_idle_en, rx_idle_en, hold_req;
  int no_gap_left, stall_left, hold_left;
  dir_row_t dir_tab [24];

  function automatic void remote_clear();
    remote_m = '0;
    for (int i = 0; i < 8; i++) begin
      press_t[i] = '0;
      due_t[i] = '0;
    end
    last_rem_t = '0;
  endfunction

  function automatic logic joypad_irq_eval();
    logic [7:0] cur;
    cur = touch_m | remote_m;
    joypad_irq_eval = |(cur & ~checked_m);
    checked_m = cur;
  endfunction

  function automatic out_item_t joypad_predict(input in_item_t it);
    out_item_t  r;
    logic       irq;
    logic       pending;
    logic [2:0] ci;
    logic [31:0] earliest;
    logic [7:0] merged;
    irq = 1'b0;
    ci = it.control_index[2:0];
    case (opcode_t'(it.opcode))
      OP_TOUCH: begin
        touch_m = '0;
        if (it.touch_present) begin
          if (it.touch_zone < 8) touch_m = 8'b1 << it.touch_zone;
          irq = joypad_irq_eval();
        end
      end
      OP_REMOTE: begin
        if (it.control_index < 8) begin
          if (it.pressed) begin
            if (!remote_m[ci]) press_t[ci] = it.now_ms;
            due_t[ci] = '0;
            remote_m[ci] = 1'b1;
          end else begin
            earliest = press_t[ci] + 32'(min_press);
            due_t[ci] = (it.now_ms < earliest) ? earliest : it.now_ms;
          end
        end
        last_rem_t = it.now_ms;
      end
      OP_TICK: begin
        pending = 1'b0;
        for (int i = 0; i < 8; i++) if (due_t[i] != 0) pending = 1'b1;
        if (remote_m != 0 || pending) begin
          if (remote_m != 0 && rem_timeout != 0 && last_rem_t != 0 &&
              it.now_ms >= last_rem_t && (it.now_ms - last_rem_t) > 32'(rem_timeout))
            remote_clear();
          for (int i = 0; i < 8; i++) begin
            if (due_t[i] != 0 && it.now_ms >= due_t[i]) begin
              remote_m[i] = 1'b0;
              due_t[i] = '0;
            end
          end
          irq = joypad_irq_eval();
        end
      end
      default: remote_clear();
    endcase
    merged = touch_m | remote_m;
    r.merged_buttons    = merged[3:0];
    r.merged_directions = merged[7:4];
    r.remote_buttons    = remote_m[3:0];
    r.remote_directions = remote_m[7:4];
    r.joypad_irq        = irq;
    return r;
  endfunction

  function automatic in_item_t ev(input opcode_t op, input logic present, input logic [3:0] zone,
                                  input logic [3:0] ctrl, input logic down,
                                  input logic [31:0] now);
    in_item_t it;
    it.opcode = op;
    it.touch_present = present;
    it.touch_zone = zone;
    it.control_index = ctrl;
    it.pressed = down;
    it.now_ms = now;
    return it;
  endfunction

  function automatic out_item_t res(input logic [3:0] mb, input logic [3:0] md,
                                    input logic [3:0] rb, input logic [3:0] rd,
                                    input logic irq);
    out_item_t r;
    r.merged_buttons = mb;
    r.merged_directions = md;
    r.remote_buttons = rb;
    r.remote_directions = rd;
    r.joypad_irq = irq;
    return r;
  endfunction

  function automatic in_item_t gen_event();
    in_item_t it;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    it.opcode = (sel < 25) ? OP_TOUCH : (sel < 65) ? OP_REMOTE : (sel < 95) ? OP_TICK : OP_CLEAR;
    it.touch_present = 1'($urandom_range(0, 1));
    it.touch_zone = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(0, 8));
    it.control_index = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                   : 4'($urandom_range(0, 7));
    it.pressed = 1'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    if (sel < 3) t_now = $urandom();
    else if (sel < 10) t_now = t_now + $urandom_range(0, 70000);
    else t_now = t_now + $urandom_range(0, 40);
    it.now_ms = t_now;
    return it;
  endfunction

  task automatic offer_event(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t r;
    @(negedge clk);
    in_chan.valid         = 1'b1;
    in_chan.opcode        = it.opcode;
    in_chan.touch_present = it.touch_present;
    in_chan.touch_zone    = it.touch_zone;
    in_chan.control_index = it.control_index;
    in_chan.pressed       = it.pressed;
    in_chan.now_ms        = it.now_ms;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    r = joypad_predict(it);
    expected_joypad_q.push_back(typed ? typed_res : r);
    events_sent++;
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    in_chan.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (expected_joypad_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_MIN_PRESS) min_press = val;
    else rem_timeout = val;
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] mp, input logic [CFG_W-1:0] tmo,
                              input int n, input bit with_hold, input bit new_cfg);
    if (new_cfg) begin
      wait_drained();
      write_reg(CFG_MIN_PRESS, mp);
      write_reg(CFG_REMOTE_TIMEOUT, tmo);
    end
    phases_run++;
    for (int k = 0; k < n; k++) begin
      if (with_hold && k == n / 4) begin
        hold_req = 1'b1;
        no_gap_left = 40;
      end
      if (k == n / 2) wait_drained();
      if (no_gap_left > 0) no_gap_left--;
      else if (tx_idle_en && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 11));
      offer_event(gen_event(), 1'b0, '0);
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_chan.ready = 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_chan.ready = 1'b0;
    end else begin
      out_chan.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t got, want;
    if (rst_n === 1'b1) begin
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        got.merged_buttons    = out_chan.merged_buttons;
        got.merged_directions = out_chan.merged_directions;
        got.remote_buttons    = out_chan.remote_buttons;
        got.remote_directions = out_chan.remote_directions;
        got.joypad_irq        = out_chan.joypad_irq;
        if (expected_joypad_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: mb=%h md=%h rb=%h rd=%h irq=%b", got.merged_buttons,
                     got.merged_directions, got.remote_buttons, got.remote_directions,
                     got.joypad_irq);
        end else begin
          want = expected_joypad_q.pop_front();
          if (got.merged_buttons !== want.merged_buttons ||
              got.merged_directions !== want.merged_directions ||
              got.remote_buttons !== want.remote_buttons ||
              got.remote_directions !== want.remote_directions ||
              got.joypad_irq !== want.joypad_irq) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected mb=%h md=%h rb=%h rd=%h irq=%b, got mb=%h md=%h rb=%h rd=%h irq=%b",
                       results_checked, want.merged_buttons, want.merged_directions,
                       want.remote_buttons, want.remote_directions, want.joypad_irq,
                       got.merged_buttons, got.merged_directions, got.remote_buttons,
                       got.remote_directions, got.joypad_irq);
          end
        end
        results_checked++;
      end
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", stall_cycles);
        $display("FAIL joypad_merge_min_press_qualifier_core");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.opcode = '0;
    in_chan.touch_present = 1'b0;
    in_chan.touch_zone = '0;
    in_chan.control_index = '0;
    in_chan.pressed = 1'b0;
    in_chan.now_ms = '0;
    out_chan.ready = 1'b0;
    events_sent = 0;
    results_checked = 0;
    mismatches = 0;
    stall_cycles = 0;
    phases_run = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_req = 1'b0;
    no_gap_left = 0;
    stall_left = 0;
    hold_left = 0;
    t_now = 32'd1000;
    min_press = MIN_PRESS_RST;
    rem_timeout = REMOTE_TIMEOUT_RST;
    touch_m = '0;
    checked_m = '0;
    remote_clear();

    // time wrap and a zero release time are in the remote rows near the end
    dir_tab = '{
      '{ev(OP_TOUCH,  1'b0, 4'd0,  4'd0,  1'b0, 32'd0),        1'b1, res(0, 0, 0, 0, 0)},
      '{ev(OP_TOUCH,  1'b1, 4'd0,  4'd0,  1'b0, 32'd0),        1'b1, res(1, 0, 0, 0, 1)},
      '{ev(OP_TOUCH,  1'b1, 4'd7,  4'd15, 1'b1, 32'hFFFFFFFF), 1'b1, res(0, 8, 0, 0, 1)},
      '{ev(OP_TOUCH,  1'b1, 4'd8,  4'd0,  1'b0, 32'd0),        1'b1, res(0, 0, 0, 0, 0)},
      '{ev(OP_TOUCH,  1'b1, 4'd15, 4'd0,  1'b0, 32'd0),        1'b1, res(0, 0, 0, 0, 0)},
      '{ev(OP_REMOTE, 1'b0, 4'd0,  4'd1,  1'b1, 32'd100),      1'b1, res(2, 0, 2, 0, 0)},
      '{ev(OP_REMOTE, 1'b1, 4'd15, 4'd1,  1'b1, 32'd120),      1'b0, '0},
      '{ev(OP_REMOTE, 1'b0, 4'd0,  4'd1,  1'b0, 32'd110),      1'b0, '0},
      '{ev(OP_TICK,   1'b0, 4'd0,  4'd0,  1'b0, 32'd149),      1'b0, '0},
      '{ev(OP_TICK,   1'b0, 4'd0,  4'd0,  1'b0, 32'd150),      1'b0, '0},
      '{ev(OP_TICK,   1'b1, 4'd15, 4'd15, 1'b1, 32'd200),      1'b0, '0},
      '{ev(OP_REMOTE, 1'b0, 4'd0,  4'd8,  1'b1, 32'd300),      1'b0, '0},
      '{ev(OP_REMOTE, 1'b0, 4'd0,  4'd15, 1'b0, 32'hFFFFFFFF), 1'b0, '0},
      '{ev(OP_REMOTE, 1'b0, 4'd0,  4'd4,  1'b1, 32'hFFFFFFF0), 1'b0, '0},
      '{ev(OP_REMOTE, 1'b0, 4'd0,  4'd4,  1'b0, 32'hFFFFFFF8), 1'b0, '0},
      '{ev(OP_TICK,   1'b0, 4'd0,  4'd0,  1'b0, 32'hFFFFFFFF), 1'b0, '0},
      '{ev(OP_REMOTE, 1'b0, 4'd0,  4'd6,  1'b0, 32'd0),        1'b0, '0},
      '{ev(OP_TICK,   1'b0, 4'd0,  4'd0,  1'b0, 32'd60),       1'b0, '0},
      '{ev(OP_REMOTE, 1'b0, 4'd0,  4'd3,  1'b1, 32'hFFFFFFCE), 1'b0, '0},
      '{ev(OP_REMOTE, 1'b0, 4'd0,  4'd3,  1'b0, 32'd0),        1'b0, '0},
      '{ev(OP_TICK,   1'b0, 4'd0,  4'd0,  1'b0, 32'd5),        1'b0, '0},
      '{ev(OP_TOUCH,  1'b1, 4'd5,  4'd0,  1'b0, 32'd7),        1'b0, '0},
      '{ev(OP_CLEAR,  1'b1, 4'd15, 4'd15, 1'b1, 32'hFFFFFFFF), 1'b1, res(0, 2, 0, 0, 0)},
      '{ev(OP_TOUCH,  1'b0, 4'd5,  4'd0,  1'b0, 32'd8),        1'b1, res(0, 0, 0, 0, 0)}
    };

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) offer_event(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].res);

    random_phase(MIN_PRESS_RST, REMOTE_TIMEOUT_RST, 200, 1'b0, 1'b0);
    random_phase(16'd0, 16'd0, 225, 1'b0, 1'b1);
    random_phase(16'hFFFF, 16'hFFFF, 225, 1'b1, 1'b1);
    random_phase(16'd20, 16'd100, 225, 1'b0, 1'b1);
    random_phase(16'd5, 16'd1, 225, 1'b0, 1'b1);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_phase(16'($urandom_range(0, 300)), 16'($urandom_range(1, 400)), 225, 1'b0, 1'b1);

    wait_drained();
    $display("covered %0d events (touch, remote, tick, clear) and %0d results under %0d settings",
             events_sent, results_checked, phases_run);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && expected_joypad_q.size() == 0) begin
      $display("PASS joypad_merge_min_press_qualifier_core");
    end else begin
      $display("FAIL joypad_merge_min_press_qualifier_core");
    end
    $finish;
  end

endmodule
